FILE: src/pase_pkg.sv
// Shared constants for the packed array search and edit block.
package pase_pkg;

    // Default number of table entries
    localparam int DEFAULT_TABLE_DEPTH = 128;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 8;

    // Packed word widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

FILE: src/pase_store.sv
// Table storage: one write port, one read port with registered read data.
module pase_store import pase_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    // Write one word when asked
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read every cycle; the read data is registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/packed_array_search_edit.sv
// Packed table of signed 32-bit words with a live entry count; one request, one result word.
//
// Each input word carries a request kind in tuser (search, modify, append, remove) and a value
// and position in tdata; each request gives exactly one result word. The block takes one
// request at a time and drops tready while it works. Work runs through a table memory with
// one write port and one read port with a registered read, so each cycle reads or moves one
// entry: a search walks the entries from position 0 one per cycle and stops at the first
// match, and a remove moves every later entry down one place per cycle. Errors (out of
// range, full, empty) leave the table untouched. A finished result sits in the output
// register while the next request is taken; while that register still holds an untaken
// word, a new result waits in the done state and the block stays busy. The table is filled
// by appends after reset; entries at or beyond the live count never affect a result.
module packed_array_search_edit import pase_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] data_value, [38:32] position, [39] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // Result side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] status, [9:3] found_position, [41:10] previous_value, [49:42] live_count,
    // [55:50] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PX_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LX_W  = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam int PAD_W = OUT_DATA_W - (STATUS_W + POS_W + VALUE_W + LIVE_W);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_SRCH   = 3'd2;
    localparam logic [2:0] S_MOD_WR = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          r_state,  n_state;
    logic [KIND_W-1:0]   r_kind,   n_kind;
    logic [VALUE_W-1:0]  r_value,  n_value;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [CNT_W-1:0]    r_idx,    n_idx;
    logic [CNT_W-1:0]    r_wr_idx, n_wr_idx;
    logic                r_pend,   n_pend;
    logic                r_first,  n_first;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CNT_W-1:0]    r_found,  n_found;
    logic [VALUE_W-1:0]  r_prev,   n_prev;

    logic                r_o_valid,  n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [POS_W-1:0]    r_o_found,  n_o_found;
    logic [VALUE_W-1:0]  r_o_prev,   n_o_prev;
    logic [LIVE_W-1:0]   r_o_live,   n_o_live;

    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    logic [VALUE_W-1:0]  w_wr_data;
    logic [IDX_W-1:0]    w_rd_addr;
    logic [VALUE_W-1:0]  w_rd_data;

    logic [PX_W-1:0]     w_pos_x;
    logic [PX_W-1:0]     w_cnt_x;
    logic [PX_W-1:0]     w_found_x;
    logic [LX_W-1:0]     w_live_x;
    logic [CNT_W-1:0]    w_idx_nx;
    logic                w_in_range;
    logic                w_slot_free;

    pase_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Widened views for compares and output slices
    assign w_pos_x     = PX_W'(r_pos);
    assign w_cnt_x     = PX_W'(r_count);
    assign w_found_x   = PX_W'(r_found);
    assign w_live_x    = LX_W'(r_count);
    assign w_idx_nx    = r_idx + CNT_W'(1);
    assign w_in_range  = (w_pos_x < w_cnt_x);
    assign w_slot_free = !r_o_valid || i_m_axis_tready;

    // Sequencer and table port control
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_value    = r_value;
        n_pos      = r_pos;
        n_count    = r_count;
        n_idx      = r_idx;
        n_wr_idx   = r_wr_idx;
        n_pend     = r_pend;
        n_first    = r_first;
        n_status   = r_status;
        n_found    = r_found;
        n_prev     = r_prev;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_prev   = r_o_prev;
        n_o_live   = r_o_live;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_pos_x[IDX_W-1:0];
        w_wr_data  = r_value;
        w_rd_addr  = r_idx[IDX_W-1:0];

        // Drop the output word once taken
        if (r_o_valid && i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind  = i_s_axis_tuser;
                    n_value = i_s_axis_tdata[VALUE_W-1:0];
                    n_pos   = i_s_axis_tdata[VALUE_W +: POS_W];
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_status  = ST_OK;
                n_found   = '0;
                n_prev    = '0;
                n_idx     = '0;
                n_pend    = 1'b0;
                n_first   = 1'b1;
                w_rd_addr = w_pos_x[IDX_W-1:0];
                case (r_kind)
                    KIND_SEARCH: begin
                        n_state = S_SRCH;
                    end
                    KIND_MODIFY: begin
                        if (w_in_range) begin
                            n_state = S_MOD_WR;
                        end else begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end
                    end
                    KIND_APPEND: begin
                        if (r_count == DEPTH_C) begin
                            n_status = ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_count[IDX_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (!w_in_range) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = w_pos_x[CNT_W-1:0];
                            n_state = S_SHIFT;
                        end
                    end
                endcase
            end

            // Walk the entries: issue one read a cycle, compare the previous one
            S_SRCH: begin
                if (r_pend && (w_rd_data == r_value)) begin
                    n_found = r_wr_idx;
                    n_state = S_DONE;
                end else if (r_idx == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_pend   = 1'b1;
                    n_wr_idx = r_idx;
                    n_idx    = w_idx_nx;
                end
            end

            // Old word is back from the read; overwrite it
            S_MOD_WR: begin
                n_prev  = w_rd_data;
                w_wr_en = 1'b1;
                n_state = S_DONE;
            end

            // Move each later entry down one place
            S_SHIFT: begin
                if (r_first) begin
                    n_prev  = w_rd_data;
                    n_first = 1'b0;
                end
                w_wr_en   = r_pend;
                w_wr_addr = r_wr_idx[IDX_W-1:0];
                w_wr_data = w_rd_data;
                w_rd_addr = w_idx_nx[IDX_W-1:0];
                if (w_idx_nx < r_count) begin
                    n_pend   = 1'b1;
                    n_wr_idx = r_idx;
                    n_idx    = w_idx_nx;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            // Hand the result to the output register when it is free
            S_DONE: begin
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_found  = w_found_x[POS_W-1:0];
                    n_o_prev   = r_prev;
                    n_o_live   = w_live_x[LIVE_W-1:0];
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_first   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_first   <= n_first;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_wr_idx   <= n_wr_idx;
        r_status   <= n_status;
        r_found    <= n_found;
        r_prev     <= n_prev;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_prev   <= n_o_prev;
        r_o_live   <= n_o_live;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_o_live, r_o_prev, r_o_found, r_o_status};

endmodule
